@@ design/adm_pkg.sv @@
// adm_pkg: shared constants for the arcade drive mixer
// register index codes, configuration port sizes, default fractions
// no dependencies
package adm_pkg;

    // default data path width, signed Q2.(W-2)
    localparam int DEF_VALUE_WIDTH = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // register index codes
    localparam logic [REG_IDX_W-1:0] REG_HEADING_GAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THROTTLE_ALPHA   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEADING_ALPHA    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TURBO_LIMIT      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HEADING_DEADBAND = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPIN_THRESHOLD   = 3'd5;

    // reset values as fractions of one
    localparam int GAIN_NUM     = 9;
    localparam int GAIN_DEN     = 5;
    localparam int TALPHA_DEN   = 4;
    localparam int HALPHA_DEN   = 2;
    localparam int TURBO_DEN    = 2;
    localparam int DEADBAND_DEN = 20;
    localparam int SPIN_DEN     = 10;

endpackage

@@ design/adm_cmd_if.sv @@
// adm_cmd_if: input channel of the drive mixer, sticks and button levels
// depends on adm_pkg for the default width
interface adm_cmd_if #(
    parameter int VALUE_WIDTH = adm_pkg::DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] throttle_stick;
    logic signed [VALUE_WIDTH-1:0] heading_stick;
    logic                          antiturbo_button;
    logic                          smoothing_button;
    logic                          shifter_button;

    modport source (
        output valid, throttle_stick, heading_stick,
        output antiturbo_button, smoothing_button, shifter_button,
        input  ready
    );

    modport sink (
        input  valid, throttle_stick, heading_stick,
        input  antiturbo_button, smoothing_button, shifter_button,
        output ready
    );
endinterface

@@ design/adm_drv_if.sv @@
// adm_drv_if: result channel of the drive mixer, motor commands and mode flags
// depends on adm_pkg for the default width
interface adm_drv_if #(
    parameter int VALUE_WIDTH = adm_pkg::DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] left_drive;
    logic signed [VALUE_WIDTH-1:0] right_drive;
    logic                          high_gear;
    logic                          quick_turn;
    logic                          anti_turbo_active;
    logic                          smoothing_active;

    modport source (
        output valid, left_drive, right_drive,
        output high_gear, quick_turn, anti_turbo_active, smoothing_active,
        input  ready
    );

    modport sink (
        input  valid, left_drive, right_drive,
        input  high_gear, quick_turn, anti_turbo_active, smoothing_active,
        output ready
    );
endinterface

@@ design/arcade_drive_mixer.sv @@
// arcade_drive_mixer: arcade drive with quick turn on one shared multiplier
// sequence: after the input transfer the states TURBO_T, TURBO_H, SMOOTH_T, SMOOTH_H, LEVEL_H,
//   ANG1, ANG2 and MIX step the shared multiplier through six products; MIX waits for a free
//   output register, and a new input is taken only back in IDLE; a result waiting in the output
//   register does not block the next input transfer
// reset: asynchronous, active low; levels and buttons zero, smoothing on, registers default
module arcade_drive_mixer #(
    parameter int VALUE_WIDTH = adm_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    adm_cmd_if.sink                       cmd,
    adm_drv_if.source                     drv,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [adm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [adm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);
    import adm_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int F     = W - 2;
    localparam int XW    = W + 5;
    localparam int AW    = W + 2;
    localparam int BW    = W + 1;
    localparam int PW    = AW + BW;
    localparam int ONE_I = 1 << F;

    localparam logic [W-1:0]        ONE_U = W'(ONE_I);
    localparam logic signed [W-1:0] ONE_S = W'(ONE_I);

    localparam logic [W-1:0]   GAIN_RST   = W'((ONE_I * GAIN_NUM) / GAIN_DEN);
    localparam logic [W-2:0]   TALPHA_RST = (W-1)'(ONE_I / TALPHA_DEN);
    localparam logic [W-2:0]   HALPHA_RST = (W-1)'(ONE_I / HALPHA_DEN);
    localparam logic [W-2:0]   TURBO_RST  = (W-1)'(ONE_I / TURBO_DEN);
    localparam logic [W-2:0]   DEADB_RST  = (W-1)'(ONE_I / DEADBAND_DEN);
    localparam logic [W-2:0]   SPIN_RST   = (W-1)'(ONE_I / SPIN_DEN);

    // sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_TURBO_T  = 4'd1;
    localparam logic [ST_W-1:0] ST_TURBO_H  = 4'd2;
    localparam logic [ST_W-1:0] ST_SMOOTH_T = 4'd3;
    localparam logic [ST_W-1:0] ST_SMOOTH_H = 4'd4;
    localparam logic [ST_W-1:0] ST_LEVEL_H  = 4'd5;
    localparam logic [ST_W-1:0] ST_ANG1     = 4'd6;
    localparam logic [ST_W-1:0] ST_ANG2     = 4'd7;
    localparam logic [ST_W-1:0] ST_MIX      = 4'd8;

    // sign extend a level to the wide working width
    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
        ext = $signed({{(XW-W){v[W-1]}}, v});
    endfunction

    // symmetric clamp to plus or minus lim
    function automatic logic signed [W-1:0] clamp_sym(input logic signed [XW-1:0] v,
                                                      input logic [W-1:0] lim);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = $signed({{(XW-W){1'b0}}, lim});
        lo = -hi;
        if (v > hi) begin
            clamp_sym = hi[W-1:0];
        end else if (v < lo) begin
            clamp_sym = lo[W-1:0];
        end else begin
            clamp_sym = v[W-1:0];
        end
    endfunction

    // configuration registers
    logic [W-1:0] heading_gain_reg;
    logic [W-2:0] throttle_alpha_reg;
    logic [W-2:0] heading_alpha_reg;
    logic [W-2:0] turbo_limit_reg;
    logic [W-2:0] heading_deadband_reg;
    logic [W-2:0] spin_threshold_reg;

    // control and state
    logic [ST_W-1:0]      state_reg;
    logic [ST_W-1:0]      state_next;
    logic signed [W-1:0]  tlevel_reg;
    logic signed [W-1:0]  hlevel_reg;
    logic                 turbo_flag_reg;
    logic                 smooth_flag_reg;
    logic                 gear_flag_reg;
    logic [2:0]           buttons_reg;
    logic                 out_valid_reg;

    // payload
    logic signed [W-1:0]  x_t_reg;
    logic signed [W-1:0]  x_h_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [W-1:0]  left_reg;
    logic signed [W-1:0]  right_reg;
    logic                 qt_reg;
    logic                 gear_out_reg;
    logic                 turbo_out_reg;
    logic                 smooth_out_reg;

    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    logic                 in_xfer;
    logic                 out_free;
    logic [2:0]           buttons_now;
    logic [2:0]           rise;

    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] scaled;
    logic [W-1:0]         abs_t;
    logic [W-1:0]         abs_h;
    logic                 qt;
    logic                 dead_ok;
    logic signed [XW-1:0] ang;
    logic signed [XW-1:0] sum_l;
    logic signed [XW-1:0] sum_r;
    logic signed [XW-1:0] mix_l;
    logic signed [XW-1:0] mix_r;

    // apb decode and read back
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_HEADING_GAIN:     prdata = CFG_DATA_W'(heading_gain_reg);
            REG_THROTTLE_ALPHA:   prdata = CFG_DATA_W'(throttle_alpha_reg);
            REG_HEADING_ALPHA:    prdata = CFG_DATA_W'(heading_alpha_reg);
            REG_TURBO_LIMIT:      prdata = CFG_DATA_W'(turbo_limit_reg);
            REG_HEADING_DEADBAND: prdata = CFG_DATA_W'(heading_deadband_reg);
            REG_SPIN_THRESHOLD:   prdata = CFG_DATA_W'(spin_threshold_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            heading_gain_reg     <= GAIN_RST;
            throttle_alpha_reg   <= TALPHA_RST;
            heading_alpha_reg    <= HALPHA_RST;
            turbo_limit_reg      <= TURBO_RST;
            heading_deadband_reg <= DEADB_RST;
            spin_threshold_reg   <= SPIN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HEADING_GAIN:     heading_gain_reg     <= pwdata[W-1:0];
                REG_THROTTLE_ALPHA:   throttle_alpha_reg   <= pwdata[W-2:0];
                REG_HEADING_ALPHA:    heading_alpha_reg    <= pwdata[W-2:0];
                REG_TURBO_LIMIT:      turbo_limit_reg      <= pwdata[W-2:0];
                REG_HEADING_DEADBAND: heading_deadband_reg <= pwdata[W-2:0];
                REG_SPIN_THRESHOLD:   spin_threshold_reg   <= pwdata[W-2:0];
                default:              ;
            endcase
        end
    end

    // handshake
    assign cmd.ready = (state_reg == ST_IDLE);
    assign in_xfer   = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || drv.ready;

    assign buttons_now = {cmd.shifter_button, cmd.smoothing_button, cmd.antiturbo_button};
    assign rise        = buttons_now & ~buttons_reg;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_TURBO_T: begin
                op_a = $signed({{(AW-W){x_t_reg[W-1]}}, x_t_reg});
                op_b = $signed({2'b00, turbo_limit_reg});
            end
            ST_TURBO_H: begin
                op_a = $signed({{(AW-W){x_h_reg[W-1]}}, x_h_reg});
                op_b = $signed({2'b00, turbo_limit_reg});
            end
            ST_SMOOTH_T: begin
                op_a = $signed({{(AW-W){x_t_reg[W-1]}}, x_t_reg})
                     - $signed({{(AW-W){tlevel_reg[W-1]}}, tlevel_reg});
                op_b = $signed({2'b00, throttle_alpha_reg});
            end
            ST_SMOOTH_H: begin
                op_a = $signed({{(AW-W){x_h_reg[W-1]}}, x_h_reg})
                     - $signed({{(AW-W){hlevel_reg[W-1]}}, hlevel_reg});
                op_b = $signed({2'b00, heading_alpha_reg});
            end
            ST_ANG1: begin
                op_a = $signed({2'b00, abs_t});
                op_b = $signed({hlevel_reg[W-1], hlevel_reg});
            end
            ST_ANG2: begin
                op_a = scaled[AW-1:0];
                op_b = $signed({1'b0, heading_gain_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // floor shift of the registered product
    assign scaled = prod_reg[PW-1:F];

    // magnitudes and mode decisions on the stored levels
    assign abs_t   = tlevel_reg[W-1] ? W'(-tlevel_reg) : W'(tlevel_reg);
    assign abs_h   = hlevel_reg[W-1] ? W'(-hlevel_reg) : W'(hlevel_reg);
    assign qt      = (abs_t < {1'b0, spin_threshold_reg})
                  && (abs_h > {1'b0, spin_threshold_reg});
    assign dead_ok = abs_h > {1'b0, heading_deadband_reg};

    // side mix with sign gating
    always_comb
    begin
        ang   = dead_ok ? scaled : '0;
        sum_l = ext(tlevel_reg) + ang;
        sum_r = ext(tlevel_reg) - ang;
        mix_l = sum_l;
        mix_r = sum_r;
        if (qt) begin
            mix_l = ext(hlevel_reg);
            mix_r = -ext(hlevel_reg);
        end else if (!tlevel_reg[W-1]) begin
            if (sum_l[XW-1]) mix_l = '0;
            if (sum_r[XW-1]) mix_r = '0;
        end else begin
            if (!sum_l[XW-1]) mix_l = '0;
            if (!sum_r[XW-1]) mix_r = '0;
        end
    end

    // sequencer next state
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:     state_next = in_xfer ? ST_TURBO_T : ST_IDLE;
            ST_TURBO_T:  state_next = ST_TURBO_H;
            ST_TURBO_H:  state_next = ST_SMOOTH_T;
            ST_SMOOTH_T: state_next = ST_SMOOTH_H;
            ST_SMOOTH_H: state_next = ST_LEVEL_H;
            ST_LEVEL_H:  state_next = ST_ANG1;
            ST_ANG1:     state_next = ST_ANG2;
            ST_ANG2:     state_next = ST_MIX;
            ST_MIX:      state_next = out_free ? ST_IDLE : ST_MIX;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control state, flags and stored levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            tlevel_reg      <= '0;
            hlevel_reg      <= '0;
            turbo_flag_reg  <= 1'b0;
            smooth_flag_reg <= 1'b1;
            gear_flag_reg   <= 1'b0;
            buttons_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                buttons_reg     <= buttons_now;
                turbo_flag_reg  <= turbo_flag_reg ^ rise[0];
                smooth_flag_reg <= smooth_flag_reg ^ rise[1];
                gear_flag_reg   <= gear_flag_reg ^ rise[2];
            end
            if (state_reg == ST_SMOOTH_H) begin
                tlevel_reg <= smooth_flag_reg ? clamp_sym(ext(tlevel_reg) + scaled, ONE_U)
                                              : clamp_sym(ext(x_t_reg), ONE_U);
            end
            if (state_reg == ST_LEVEL_H) begin
                hlevel_reg <= smooth_flag_reg ? clamp_sym(ext(hlevel_reg) + scaled, ONE_U)
                                              : clamp_sym(ext(x_h_reg), ONE_U);
            end
            if ((state_reg == ST_MIX) && out_free) begin
                out_valid_reg <= 1'b1;
                if (qt) tlevel_reg <= '0;
            end else if (drv.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: product, shaped sticks, result register
    always_ff @(posedge clk)
    begin
        // angular term held while the mix step waits for the output
        if (state_reg != ST_MIX) begin
            prod_reg <= prod;
        end
        if (in_xfer) begin
            x_t_reg <= cmd.throttle_stick;
            x_h_reg <= cmd.heading_stick;
        end
        if ((state_reg == ST_TURBO_H) && turbo_flag_reg) begin
            x_t_reg <= clamp_sym(scaled, {1'b0, turbo_limit_reg});
        end
        if ((state_reg == ST_SMOOTH_T) && turbo_flag_reg) begin
            x_h_reg <= clamp_sym(scaled, {1'b0, turbo_limit_reg});
        end
        if ((state_reg == ST_MIX) && out_free) begin
            left_reg       <= clamp_sym(mix_l, ONE_U);
            right_reg      <= clamp_sym(mix_r, ONE_U);
            qt_reg         <= qt;
            gear_out_reg   <= gear_flag_reg;
            turbo_out_reg  <= turbo_flag_reg;
            smooth_out_reg <= smooth_flag_reg;
        end
    end

    // result channel
    assign drv.valid             = out_valid_reg;
    assign drv.left_drive        = left_reg;
    assign drv.right_drive       = right_reg;
    assign drv.quick_turn        = qt_reg;
    assign drv.high_gear         = gear_out_reg;
    assign drv.anti_turbo_active = turbo_out_reg;
    assign drv.smoothing_active  = smooth_out_reg;

`ifndef SYNTHESIS
    // an accepted item always starts the sequence at the first product
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_TURBO_T))
        else $error("sequencer did not start after input transfer");

    // a new result only appears out of the mix step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drv.valid) |-> ($past(state_reg) == ST_MIX))
        else $error("result valid rose outside the mix step");

    // stored levels stay within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        (tlevel_reg <= ONE_S) && (tlevel_reg >= -ONE_S)
        && (hlevel_reg <= ONE_S) && (hlevel_reg >= -ONE_S))
        else $error("stored level outside plus or minus one");

    // quick turn drives the sides exactly opposite
    assert property (@(posedge clk) disable iff (!rst_n)
        (drv.valid && drv.quick_turn) |-> ((drv.left_drive + drv.right_drive) == '0))
        else $error("quick turn sides not opposite");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for arcade_drive_mixer, a directed stimulus table then random ticks
// depends on adm_pkg, adm_cmd_if, adm_drv_if and the mixer rtl; checks every drive transfer
module tb;
    import adm_pkg::*;

    localparam int VW = DEF_VALUE_WIDTH;
    localparam int FRAC = VW - 2;
    localparam longint UNITY = longint'(1) << FRAC;
    localparam int ROWS = 23;
    localparam int CHUNKS = 7;
    localparam int CHUNK_ITEMS = 250;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_NS = 4_000_000;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

    typedef logic signed [VW-1:0] val_t;

    // buttons: bit0 anti-turbo, bit1 smoothing, bit2 shifter
    typedef struct packed {
        val_t       throttle;
        val_t       heading;
        logic [2:0] buttons;
    } stick_cmd_t;

    typedef struct packed {
        val_t left;
        val_t right;
        logic high_gear;
        logic quick_turn;
        logic anti_turbo;
        logic smoothing;
    } drive_out_t;

    typedef struct packed {
        stick_cmd_t cmd;
        logic       typed;
        drive_out_t out;
    } steer_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    adm_cmd_if #(.VALUE_WIDTH(VW)) cmd_ch ();
    adm_drv_if #(.VALUE_WIDTH(VW)) drv_ch ();

    arcade_drive_mixer #(.VALUE_WIDTH(VW)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .drv     (drv_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and the mixer state
    longint gain_q, thr_alpha_q, hdg_alpha_q, turbo_q, deadband_q, spin_q;
    longint thr_level, hdg_level;
    logic turbo_on, smooth_on, gear_high;
    logic [2:0] btn_prev;

    drive_out_t drive_exp[$];
    steer_row_t steer_table[ROWS];
    logic [2:0] btn_drive;
    int tx_idle_pct;
    int rx_idle_pct;
    int fail_cnt;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("tb failed");
        $finish;
    end

    function automatic longint floor_frac(longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // anti-turbo scale and clamp, optional low-pass, clamp to one
    function automatic longint shape_axis(longint stick, longint lvl, longint alpha);
        longint x;
        x = stick;
        if (turbo_on)
            x = clamp_to(floor_frac(x * turbo_q), turbo_q);
        if (smooth_on)
            x = lvl + floor_frac((x - lvl) * alpha);
        return clamp_to(x, UNITY);
    endfunction

    // one control tick: button edges, shaping, quick turn or arcade mix
    function automatic drive_out_t predict_drive(stick_cmd_t c);
        logic [2:0] rise;
        longint ang;
        longint l;
        longint r;
        logic spin;
        drive_out_t o;
        rise = c.buttons & ~btn_prev;
        btn_prev = c.buttons;
        if (rise[0])
            turbo_on = !turbo_on;
        if (rise[1])
            smooth_on = !smooth_on;
        if (rise[2])
            gear_high = !gear_high;
        thr_level = shape_axis(longint'($signed(c.throttle)), thr_level, thr_alpha_q);
        hdg_level = shape_axis(longint'($signed(c.heading)), hdg_level, hdg_alpha_q);
        spin = (mag(thr_level) < spin_q) && (mag(hdg_level) > spin_q);
        if (spin)
        begin
            thr_level = 0;
            l = hdg_level;
            r = -hdg_level;
        end
        else
        begin
            ang = 0;
            if (mag(hdg_level) > deadband_q)
                ang = floor_frac(floor_frac(mag(thr_level) * hdg_level) * gain_q);
            l = thr_level + ang;
            r = thr_level - ang;
            // sides never oppose the throttle sign
            if (thr_level >= 0)
            begin
                if (l < 0)
                    l = 0;
                if (r < 0)
                    r = 0;
            end
            else
            begin
                if (l > 0)
                    l = 0;
                if (r > 0)
                    r = 0;
            end
        end
        o.left = val_t'(clamp_to(l, UNITY));
        o.right = val_t'(clamp_to(r, UNITY));
        o.high_gear = gear_high;
        o.quick_turn = spin;
        o.anti_turbo = turbo_on;
        o.smoothing = smooth_on;
        return o;
    endfunction

    function automatic steer_row_t table_row(int t, int h, logic [2:0] b, logic typed,
                                             int l, int r, logic [3:0] flags);
        steer_row_t row;
        row.cmd.throttle = val_t'(t);
        row.cmd.heading = val_t'(h);
        row.cmd.buttons = b;
        row.typed = typed;
        row.out.left = val_t'(l);
        row.out.right = val_t'(r);
        {row.out.high_gear, row.out.quick_turn, row.out.anti_turbo, row.out.smoothing} = flags;
        return row;
    endfunction

    // stick values biased toward the extremes and the spin threshold
    function automatic val_t random_stick();
        int r;
        int span;
        r = $urandom_range(99);
        span = int'(2 * spin_q) + 64;
        if (r < 10)
            return val_t'($urandom);
        else if (r < 20)
        begin
            case ($urandom_range(4))
                0: return val_t'(UNITY);
                1: return val_t'(-UNITY);
                2: return val_t'(0);
                3: return val_t'(32767);
                default: return val_t'(-32768);
            endcase
        end
        else if (r < 50)
            return val_t'(int'($urandom_range(2 * span)) - span);
        else
            return val_t'(int'($urandom_range(2 * UNITY)) - int'(UNITY));
    endfunction

    function automatic stick_cmd_t random_cmd();
        stick_cmd_t c;
        // buttons held for a while, then toggled
        for (int b = 0; b < 3; b++)
        begin
            if ($urandom_range(99) < 12)
                btn_drive[b] = ~btn_drive[b];
        end
        c.throttle = random_stick();
        c.heading = random_stick();
        c.buttons = btn_drive;
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_reg(logic wide);
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(99) < 15 || wide)
            v = $urandom;
        else
            v = $urandom_range(UNITY);
        return v;
    endfunction

    // apb write: setup then access, model updated at the write edge
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEADING_GAIN:     gain_q = longint'(data[VW-1:0]);
            REG_THROTTLE_ALPHA:   thr_alpha_q = longint'(data[VW-2:0]);
            REG_HEADING_ALPHA:    hdg_alpha_q = longint'(data[VW-2:0]);
            REG_TURBO_LIMIT:      turbo_q = longint'(data[VW-2:0]);
            REG_HEADING_DEADBAND: deadband_q = longint'(data[VW-2:0]);
            REG_SPIN_THRESHOLD:   spin_q = longint'(data[VW-2:0]);
            default: ;
        endcase
    endtask

    // present one tick with random sender gaps, predict at the transfer edge
    task automatic send_cmd(input stick_cmd_t c, input logic typed, input drive_out_t typed_out);
        drive_out_t pred;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.throttle_stick <= val_t'($urandom);
            cmd_ch.heading_stick <= val_t'($urandom);
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.throttle_stick <= c.throttle;
        cmd_ch.heading_stick <= c.heading;
        cmd_ch.antiturbo_button <= c.buttons[0];
        cmd_ch.smoothing_button <= c.buttons[1];
        cmd_ch.shifter_button <= c.buttons[2];
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pred = predict_drive(c);
        drive_exp.push_back(typed ? typed_out : pred);
    endtask

    // stop sending, wait for every expected transfer, then let the design settle
    task automatic drain_and_settle();
        cmd_ch.valid <= 1'b0;
        while (drive_exp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // receiver stalls
    always @(posedge clk)
        drv_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    // result check against the oldest expectation
    always @(posedge clk)
    begin : drive_monitor
        drive_out_t seen;
        drive_out_t want;
        if (rst_n && drv_ch.valid && drv_ch.ready)
        begin
            seen = {drv_ch.left_drive, drv_ch.right_drive, drv_ch.high_gear,
                    drv_ch.quick_turn, drv_ch.anti_turbo_active, drv_ch.smoothing_active};
            if (drive_exp.size() == 0)
            begin
                if (fail_cnt < 10)
                    $display("unexpected drive transfer: L=%0d R=%0d", $signed(seen.left),
                             $signed(seen.right));
                fail_cnt++;
            end
            else
            begin
                want = drive_exp.pop_front();
                if (seen !== want)
                begin
                    if (fail_cnt < 10)
                        $display("drive mismatch: exp L=%0d R=%0d g%b q%b at%b sm%b, got L=%0d R=%0d g%b q%b at%b sm%b",
                                 $signed(want.left), $signed(want.right), want.high_gear,
                                 want.quick_turn, want.anti_turbo, want.smoothing,
                                 $signed(seen.left), $signed(seen.right), seen.high_gear,
                                 seen.quick_turn, seen.anti_turbo, seen.smoothing);
                    fail_cnt++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        logic [CFG_DATA_W-1:0] regs [6];
        logic [CFG_DATA_W-1:0] upper;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.throttle_stick = '0;
        cmd_ch.heading_stick = '0;
        cmd_ch.antiturbo_button = 1'b0;
        cmd_ch.smoothing_button = 1'b0;
        cmd_ch.shifter_button = 1'b0;
        drv_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_cnt = 0;
        btn_drive = 3'b000;
        tx_idle_pct = 29;
        rx_idle_pct = 50;

        // state after reset
        gain_q = 29491;
        thr_alpha_q = 4096;
        hdg_alpha_q = 8192;
        turbo_q = 8192;
        deadband_q = 819;
        spin_q = 1638;
        thr_level = 0;
        hdg_level = 0;
        turbo_on = 1'b0;
        smooth_on = 1'b1;
        gear_high = 1'b0;
        btn_prev = 3'b000;

        // throttle, heading, {shifter, smoothing, anti-turbo}, typed, left, right,
        // {gear, quick turn, anti-turbo, smoothing}
        steer_table[0]  = table_row(0, 0, 3'b000, 1, 0, 0, 4'b0001);
        // smoothing off, full sticks pass straight through
        steer_table[1]  = table_row(16384, 0, 3'b010, 1, 16384, 16384, 4'b0000);
        steer_table[2]  = table_row(-16384, 0, 3'b010, 1, -16384, -16384, 4'b0000);
        // quick turn both ways
        steer_table[3]  = table_row(0, 16384, 3'b010, 1, 16384, -16384, 4'b0100);
        steer_table[4]  = table_row(0, -16384, 3'b010, 1, -16384, 16384, 4'b0100);
        // sticks beyond one are clamped
        steer_table[5]  = table_row(32767, 0, 3'b010, 1, 16384, 16384, 4'b0000);
        steer_table[6]  = table_row(-32768, 0, 3'b010, 1, -16384, -16384, 4'b0000);
        // full mix, a side opposing the throttle goes to zero
        steer_table[7]  = table_row(16384, 16384, 3'b010, 1, 16384, 0, 4'b0000);
        steer_table[8]  = table_row(-16384, 16384, 3'b010, 1, 0, -16384, 4'b0000);
        // deadband edge
        steer_table[9]  = table_row(8192, 800, 3'b010, 1, 8192, 8192, 4'b0000);
        steer_table[10] = table_row(8192, 820, 3'b010, 0, 0, 0, 4'b0000);
        // spin threshold edge
        steer_table[11] = table_row(1637, 1639, 3'b010, 1, 1639, -1639, 4'b0100);
        steer_table[12] = table_row(1638, 1639, 3'b010, 0, 0, 0, 4'b0000);
        // anti-turbo on, scale then clamp
        steer_table[13] = table_row(16384, 0, 3'b011, 1, 8192, 8192, 4'b0010);
        steer_table[14] = table_row(32767, 0, 3'b011, 1, 8192, 8192, 4'b0010);
        steer_table[15] = table_row(-32768, 0, 3'b011, 1, -8192, -8192, 4'b0010);
        // shifter press, falling edges change nothing
        steer_table[16] = table_row(0, 0, 3'b100, 1, 0, 0, 4'b1010);
        // smoothing back on, floor rounding of small negatives
        steer_table[17] = table_row(16384, 0, 3'b110, 0, 0, 0, 4'b0000);
        steer_table[18] = table_row(-1, -1, 3'b110, 0, 0, 0, 4'b0000);
        steer_table[19] = table_row(16384, -16384, 3'b111, 0, 0, 0, 4'b0000);
        steer_table[20] = table_row(-16384, 16384, 3'b010, 0, 0, 0, 4'b0000);
        steer_table[21] = table_row(4000, -3000, 3'b110, 0, 0, 0, 4'b0000);
        steer_table[22] = table_row(-5, 2000, 3'b000, 0, 0, 0, 4'b0000);

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROWS; i++)
            send_cmd(steer_table[i].cmd, steer_table[i].typed, steer_table[i].out);

        for (int k = 0; k < CHUNKS; k++)
        begin
            drain_and_settle();
            // sender 29 / receiver 50, then swapped, then no idling
            if (k < 3)
            begin
                tx_idle_pct = 29;
                rx_idle_pct = 50;
            end
            else if (k < 5)
            begin
                tx_idle_pct = 50;
                rx_idle_pct = 29;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // register settings: defaults, gain maximum and the rest at one, all zero, then random
            upper = '0;
            if (k == 0)
                regs = '{32'd29491, 32'd4096, 32'd8192, 32'd8192, 32'd819, 32'd1638};
            else if (k == 1)
                regs = '{32'd65535, 32'd16384, 32'd16384, 32'd16384, 32'd16384, 32'd16384};
            else if (k == 2)
                regs = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            else
            begin
                regs[0] = random_reg(1'b1);
                for (int j = 1; j < 6; j++)
                    regs[j] = random_reg(1'b0);
                upper = $urandom;
            end
            write_reg(REG_HEADING_GAIN, {upper[CFG_DATA_W-1:VW], regs[0][VW-1:0]});
            write_reg(REG_THROTTLE_ALPHA, {upper[CFG_DATA_W-1:VW-1], regs[1][VW-2:0]});
            write_reg(REG_HEADING_ALPHA, {upper[CFG_DATA_W-1:VW-1], regs[2][VW-2:0]});
            write_reg(REG_TURBO_LIMIT, {upper[CFG_DATA_W-1:VW-1], regs[3][VW-2:0]});
            write_reg(REG_HEADING_DEADBAND, {upper[CFG_DATA_W-1:VW-1], regs[4][VW-2:0]});
            write_reg(REG_SPIN_THRESHOLD, {upper[CFG_DATA_W-1:VW-1], regs[5][VW-2:0]});
            // a write to an unmapped address is ignored
            if (k == 0 || k == 4)
                write_reg(REG_UNMAPPED, $urandom);
            @(posedge clk);

            for (int n = 0; n < CHUNK_ITEMS; n++)
                send_cmd(random_cmd(), 1'b0, '0);
        end

        drain_and_settle();
        if (fail_cnt == 0 && drive_exp.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
